// ----- rtl/bmsa_pkg.sv -----
`timescale 1ns / 1ps
package bmsa_pkg;

  localparam int MEM_BYTES_DEF = 65536;
  localparam int SIZE_W = 17;
  localparam int SIZE_RESET = 65536;
  localparam logic [7:0] FILL_BYTE = 8'ha5;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic {
    ST_CLEAR,
    ST_READY
  } ctrl_state_e;

  typedef struct packed {
    logic clear;
    logic access;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_sts_t;

  function automatic logic [2:0] nbytes_of(logic [1:0] sz);
    logic [2:0] n;
    case (sz)
      SZ_BYTE: n = 3'd1;
      SZ_HALF: n = 3'd2;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/bmsa_bank.sv -----
`timescale 1ns / 1ps
module bmsa_bank #(
  parameter int DEPTH = 16384,
  parameter int AW = 14
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bmsa_ctrl.sv -----
`timescale 1ns / 1ps
module bmsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output bmsa_pkg::dp_cmd_t cmd_o,
  input  bmsa_pkg::dp_sts_t sts_i
);
  import bmsa_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        done_q, done_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = ST_READY;
        end
      end
      ST_READY: state_d = ST_READY;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    busy_o       = 1'b1;
    cmd_o.clear  = 1'b0;
    cmd_o.access = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear = 1'b1;
      ST_READY: begin
        busy_o       = 1'b0;
        cmd_o.access = start_i;
      end
      default: cmd_o.clear = 1'b0;
    endcase
  end

  assign done_d = cmd_o.access;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

endmodule

// ----- rtl/bmsa_dp.sv -----
`timescale 1ns / 1ps
module bmsa_dp #(
  parameter int MEM_BYTES = bmsa_pkg::MEM_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bmsa_pkg::dp_cmd_t           cmd_i,
  output bmsa_pkg::dp_sts_t           sts_o,
  input  logic                        cfg_we_i,
  input  logic [bmsa_pkg::SIZE_W-1:0] cfg_data_i,
  input  logic                        req_type_i,
  input  logic [1:0]                  access_size_i,
  input  logic                        sign_extend_i,
  input  logic [31:0]                 address_i,
  input  logic [31:0]                 write_data_i,
  output logic [31:0]                 read_data_o,
  output logic                        out_of_range_o
);
  import bmsa_pkg::*;

  localparam int DEPTH = (MEM_BYTES + 3) / 4;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW = $clog2(MEM_BYTES + 1);
  localparam int CW = (BW > SIZE_W + 1) ? BW : SIZE_W + 1;
  localparam int RST_ROUND = (SIZE_RESET + 15) / 16 * 16;
  localparam int BOUND_RST = (RST_ROUND > MEM_BYTES) ? MEM_BYTES : RST_ROUND;

  logic [BW-1:0] bound_q, bound_d;
  logic [CW-1:0] round_w;
  logic [AW-1:0] clr_row_q, clr_row_d;

  logic [3:0]         bank_en, bank_we;
  logic [3:0][AW-1:0] bank_addr;
  logic [3:0][7:0]    bank_wdata, bank_rdata;

  logic [3:0] rd_en_q, rd_en_d;
  logic [1:0] lo_q;
  logic [2:0] nb_q, nb_w;
  logic       sx_q;
  logic       bad_q, bad_d;

  // bound = size rounded up to 16, saturated at MEM_BYTES
  always_comb begin
    round_w = (CW'(cfg_data_i) + CW'(15)) & ~CW'(15);
    bound_d = (round_w > CW'(MEM_BYTES)) ? BW'(MEM_BYTES) : BW'(round_w);
  end

  assign clr_row_d = clr_row_q + AW'(1);
  assign sts_o.clear_last = (clr_row_q == AW'(DEPTH - 1));
  assign nb_w = nbytes_of(access_size_i);

  // lane b holds the byte at offset (b - address[1:0]) mod 4
  always_comb begin
    logic [1:0]  off;
    logic [31:0] addr;
    logic        act, ok;
    logic [31:0] wsh;
    bad_d = 1'b0;
    for (int b = 0; b < 4; b++) begin
      off  = 2'(b) - address_i[1:0];
      addr = address_i + 32'(off);
      act  = ({1'b0, off} < nb_w);
      ok   = (addr < 32'(bound_q));
      wsh  = write_data_i >> {off, 3'b000};
      rd_en_d[b] = act && ok && (req_type_i != REQ_WRITE);
      if (act && !ok) begin
        bad_d = 1'b1;
      end
      bank_en[b] = cmd_i.clear || cmd_i.access;
      if (cmd_i.clear) begin
        bank_we[b]    = 1'b1;
        bank_addr[b]  = clr_row_q;
        bank_wdata[b] = FILL_BYTE;
      end else begin
        bank_we[b]    = cmd_i.access && (req_type_i == REQ_WRITE) && act && ok;
        bank_addr[b]  = addr[AW+1:2];
        bank_wdata[b] = wsh[7:0];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    bmsa_bank #(
      .DEPTH(DEPTH),
      .AW   (AW)
    ) u_bank (
      .clk_i  (clk_i),
      .en_i   (bank_en[g]),
      .we_i   (bank_we[g]),
      .addr_i (bank_addr[g]),
      .wdata_i(bank_wdata[g]),
      .rdata_o(bank_rdata[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q   <= BW'(BOUND_RST);
      clr_row_q <= '0;
    end else begin
      if (cfg_we_i) begin
        bound_q <= bound_d;
      end
      if (cmd_i.clear) begin
        clr_row_q <= clr_row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.access) begin
      rd_en_q <= rd_en_d;
      lo_q    <= address_i[1:0];
      nb_q    <= nb_w;
      sx_q    <= sign_extend_i;
      bad_q   <= bad_d;
    end
  end

  always_comb begin
    logic [1:0]  bank;
    logic [31:0] value;
    value = '0;
    for (int i = 0; i < 4; i++) begin
      bank = lo_q + 2'(i);
      value[8*i +: 8] = rd_en_q[bank] ? bank_rdata[bank] : 8'h00;
    end
    if (sx_q) begin
      if (nb_q == 3'd1 && value[7]) begin
        value[31:8] = '1;
      end else if (nb_q == 3'd2 && value[15]) begin
        value[31:16] = '1;
      end
    end
    read_data_o = value;
  end

  assign out_of_range_o = bad_q;

endmodule

// ----- rtl/byte_memory_sized_access.sv -----
`timescale 1ns / 1ps
// Byte-addressed little-endian memory built from four byte-lane banks of
// ceil(MEM_BYTES/4) rows each. After reset the block fills every byte with
// 0xa5, one row of all four lanes per cycle, and busy_o stays high until the
// last row is written; configuration writes are taken during that time.
// Once busy_o is low it stays low and an item is accepted on every cycle with
// start_i high. The result of an item appears on done_o, read_data_o and
// out_of_range_o in the cycle after acceptance, for one cycle only; the
// receiver cannot stall it. The result comes from the registered read of the
// lane banks, and an unaligned access touches each lane once, so any byte,
// halfword or word access needs just one access of the banks.
module byte_memory_sized_access #(
  parameter int MEM_BYTES = bmsa_pkg::MEM_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        req_type_i,
  input  logic [1:0]                  access_size_i,
  input  logic                        sign_extend_i,
  input  logic [31:0]                 address_i,
  input  logic [31:0]                 write_data_i,
  output logic                        done_o,
  output logic [31:0]                 read_data_o,
  output logic                        out_of_range_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bmsa_pkg::SIZE_W-1:0] cfg_data_i
);
  import bmsa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  bmsa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  bmsa_dp #(
    .MEM_BYTES(MEM_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_type_i),
    .access_size_i (access_size_i),
    .sign_extend_i (sign_extend_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .read_data_o   (read_data_o),
    .out_of_range_o(out_of_range_o)
  );

`ifndef SYNTHESIS
  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted item produced no result");

  a_done_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o))
    else $error("result without an accepted item");

  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_type_i == REQ_WRITE) |=> (read_data_o == '0))
    else $error("write item returned nonzero read data");

  a_busy_only_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("busy asserted again after fill pass");
`endif

endmodule
